// ===== hw/rtl/gva_pkg.sv =====
// Shared types and constants for the grouped variance accumulator.
`timescale 1ns / 1ps

package gva_pkg;

  localparam logic [1:0]  CFG_SKIP_MISSING  = 2'd0;
  localparam logic [1:0]  CFG_GIVE_STD_DEV  = 2'd1;
  localparam logic [1:0]  CFG_USE_WEIGHTS   = 2'd2;
  localparam logic [1:0]  CFG_STABLE_UPDATE = 2'd3;

  localparam logic        REQ_SAMPLE  = 1'b0;
  localparam logic        REQ_READOUT = 1'b1;

  localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
  localparam logic [47:0] WT_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] STAT_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] STAT_MIN  = 48'h8000_0000_0000;

  typedef enum logic [1:0] {
    AOP_MUL,
    AOP_DIV,
    AOP_SQRT
  } arith_op_t;

  typedef enum logic [1:0] {
    SH_16,
    SH_32,
    SH_48
  } shift_t;

  typedef enum logic [1:0] {
    AR_IDLE,
    AR_MUL,
    AR_DIV,
    AR_SQRT
  } arith_state_t;

  typedef enum logic [4:0] {
    SQ_CLEAR,
    SQ_IDLE,
    SQ_FETCH,
    SQ_DECIDE,
    SQ_RATIO,
    SQ_STEP,
    SQ_DE,
    SQ_TERM,
    SQ_WX,
    SQ_XX,
    SQ_WXX,
    SQ_M32,
    SQ_C1,
    SQ_CORR,
    SQ_QUOT,
    SQ_SQRT,
    SQ_WRITE,
    SQ_RESULT
  } seq_state_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
    shift_t    sh;
  } arith_ctl_t;

  typedef struct packed {
    logic               skip_missing;
    logic               give_std_dev;
    logic               use_weights;
    logic               stable_update;
  } cfg_t;

  typedef struct packed {
    logic        [47:0] wt;
    logic signed [47:0] mean;
    logic        [63:0] spread;
    logic signed [63:0] sum;
    logic               seen;
    logic               poisoned;
  } entry_t;

  typedef struct packed {
    logic        [5:0]  group;
    logic signed [47:0] stat;
    logic               na;
  } result_t;

endpackage

// ===== hw/rtl/gva_arith.sv =====
// Shared iterative unit: 64x64 multiply with shift, radix-2 divide, integer square root.
`timescale 1ns / 1ps

module gva_arith (
  input  logic                clk,
  input  logic                rst,
  input  gva_pkg::arith_ctl_t ctl,
  input  logic [63:0]         a,
  input  logic [63:0]         b,
  output logic [63:0]         y,
  output logic                done
);

  localparam logic [6:0]  MUL_LAST   = 7'd5;
  localparam logic [6:0]  MUL_PARTS  = 7'd4;
  localparam logic [6:0]  DIV_LEN_16 = 7'd80;
  localparam logic [6:0]  DIV_LEN_32 = 7'd96;
  localparam logic [6:0]  SQRT_ITERS = 7'd32;
  localparam logic [63:0] SQRT_TOP   = 64'h4000_0000_0000_0000;

  gva_pkg::arith_state_t state, state_next;
  gva_pkg::shift_t       sh;

  logic [63:0]  opa, opb, r, q, pp, bitm;
  logic [127:0] acc, pp_sh;
  logic [6:0]   cnt, div_len;
  logic [1:0]   ofs;
  logic         sat;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_y, r_sh, tsum;
  logic         ge;

  assign mul_a   = cnt[0] ? opa[63:32] : opa[31:0];
  assign mul_b   = cnt[1] ? opb[63:32] : opb[31:0];
  assign div_len = (sh == gva_pkg::SH_16) ? DIV_LEN_16 : DIV_LEN_32;
  assign r_sh    = {r[62:0], opa[63]};
  assign ge      = (r_sh >= opb);
  assign tsum    = q + bitm;

  always_comb begin
    case (ofs)
      2'd0:    pp_sh = {64'b0, pp};
      2'd1:    pp_sh = {32'b0, pp, 32'b0};
      default: pp_sh = {pp, 64'b0};
    endcase
  end

  // keep floor(prod / 2^sh), all ones when it does not fit in 64 bits
  always_comb begin
    case (sh)
      gva_pkg::SH_16: mul_y = (acc[127:80] != '0) ? '1 : acc[79:16];
      gva_pkg::SH_32: mul_y = (acc[127:96] != '0) ? '1 : acc[95:32];
      default:        mul_y = (acc[127:112] != '0) ? '1 : acc[111:48];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gva_pkg::AR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    y          = '0;
    case (state)
      gva_pkg::AR_IDLE: begin
        if (ctl.start) begin
          case (ctl.op)
            gva_pkg::AOP_MUL:  state_next = gva_pkg::AR_MUL;
            gva_pkg::AOP_DIV:  state_next = gva_pkg::AR_DIV;
            gva_pkg::AOP_SQRT: state_next = gva_pkg::AR_SQRT;
            default:           state_next = gva_pkg::AR_IDLE;
          endcase
        end
      end
      gva_pkg::AR_MUL: begin
        if (cnt == MUL_LAST) begin
          done       = 1'b1;
          y          = mul_y;
          state_next = gva_pkg::AR_IDLE;
        end
      end
      gva_pkg::AR_DIV: begin
        if (cnt == div_len) begin
          done       = 1'b1;
          y          = sat ? '1 : q;
          state_next = gva_pkg::AR_IDLE;
        end
      end
      gva_pkg::AR_SQRT: begin
        if (cnt == SQRT_ITERS) begin
          done       = 1'b1;
          y          = q;
          state_next = gva_pkg::AR_IDLE;
        end
      end
      default: state_next = gva_pkg::AR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      gva_pkg::AR_IDLE: begin
        if (ctl.start) begin
          opa  <= a;
          opb  <= b;
          sh   <= ctl.sh;
          cnt  <= '0;
          acc  <= '0;
          q    <= '0;
          r    <= (ctl.op == gva_pkg::AOP_SQRT) ? a : '0;
          sat  <= (b == '0) || b[63];
          bitm <= SQRT_TOP;
        end
      end
      gva_pkg::AR_MUL: begin
        if (cnt != MUL_LAST) begin
          if (cnt < MUL_PARTS) begin
            pp  <= 64'(mul_a) * 64'(mul_b);
            ofs <= 2'(cnt[0]) + 2'(cnt[1]);
          end
          if (cnt != 7'd0) begin
            acc <= acc + pp_sh;
          end
          cnt <= cnt + 7'd1;
        end
      end
      gva_pkg::AR_DIV: begin
        if (cnt != div_len) begin
          if (q[63]) begin
            sat <= 1'b1;
          end
          q   <= {q[62:0], ge};
          r   <= ge ? (r_sh - opb) : r_sh;
          opa <= {opa[62:0], 1'b0};
          cnt <= cnt + 7'd1;
        end
      end
      gva_pkg::AR_SQRT: begin
        if (cnt != SQRT_ITERS) begin
          if (r >= tsum) begin
            r <= r - tsum;
            q <= {1'b0, q[63:1]} + bitm;
          end else begin
            q <= {1'b0, q[63:1]};
          end
          bitm <= {2'b0, bitm[63:2]};
          cnt  <= cnt + 7'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/gva_seq.sv =====
// Sequencer and per-group accumulator table for the grouped variance accumulator.
`timescale 1ns / 1ps

module gva_seq #(
  parameter int GROUPS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  gva_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [5:0]          group,
  input  logic signed [31:0]  value,
  input  logic                value_is_na,
  input  logic [31:0]         weight,
  input  logic                weight_is_na,
  output gva_pkg::arith_ctl_t arith_ctl,
  output logic [63:0]         arith_a,
  output logic [63:0]         arith_b,
  input  logic [63:0]         arith_y,
  input  logic                arith_done,
  input  logic                res_space,
  output logic                res_push,
  output gva_pkg::result_t    res
);

  localparam int AW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  gva_pkg::seq_state_t state, state_next;

  gva_pkg::entry_t mem [GROUPS];
  gva_pkg::entry_t rd_data, ent, wdata;
  logic            mem_we;
  logic [AW-1:0]   waddr, clr_idx;

  logic               req, vna, wna, in_range, neg, na, issued;
  logic [5:0]         g;
  logic signed [31:0] x;
  logic [31:0]        w;
  logic signed [48:0] d1;
  logic [63:0]        tmp, num;
  logic signed [47:0] stat_v;

  logic signed [47:0] x32;
  logic signed [48:0] x32_ext, mean_ext, e, divv;
  logic [48:0]        d1_mag, e_mag, divv_mag, wt_sum;
  logic [47:0]        wt_new;
  logic [31:0]        x_mag;
  logic [63:0]        sum_mag, sum_add, spread_new, sum_new;
  logic [64:0]        sp_sum, s65;
  logic               q_big, negq;

  assign x32      = {x, 16'b0};
  assign x32_ext  = {x32[47], x32};
  assign mean_ext = {ent.mean[47], ent.mean};
  assign e        = x32_ext - mean_ext;
  assign d1_mag   = d1[48] ? 49'(-d1) : 49'(d1);
  assign e_mag    = e[48] ? 49'(-e) : 49'(e);
  assign x_mag    = x[31] ? 32'(-x) : 32'(x);
  assign sum_mag  = ent.sum[63] ? 64'(-ent.sum) : 64'(ent.sum);
  assign divv     = $signed({1'b0, ent.wt}) - $signed(49'(gva_pkg::ONE_Q16));
  assign divv_mag = divv[48] ? 49'(-divv) : 49'(divv);
  assign wt_sum   = {1'b0, ent.wt} + 49'(w);
  assign wt_new   = wt_sum[48] ? gva_pkg::WT_MAX : wt_sum[47:0];

  assign sp_sum     = {1'b0, ent.spread} + {1'b0, arith_y};
  assign spread_new = sp_sum[64] ? '1 : sp_sum[63:0];
  assign sum_add    = x[31] ? (64'd0 - arith_y) : arith_y;
  assign s65        = {ent.sum[63], ent.sum} + {sum_add[63], sum_add};
  assign sum_new    = (s65[64] != s65[63]) ?
                      (s65[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF) :
                      s65[63:0];
  assign q_big      = (arith_y[63:47] != '0);
  assign negq       = (neg ^ divv[48]) && (arith_y != '0);

  assign res.group = g;
  assign res.stat  = na ? '0 : stat_v;
  assign res.na    = na;

  // table: one write port, registered read addressed by the incoming item
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[AW'(group)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gva_pkg::SQ_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    waddr      = AW'(g);
    wdata      = ent;
    res_push   = 1'b0;
    arith_ctl  = '{start: 1'b0, op: gva_pkg::AOP_MUL, sh: gva_pkg::SH_16};
    arith_a    = '0;
    arith_b    = '0;
    case (state)
      gva_pkg::SQ_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_idx;
        wdata  = '0;
        if (clr_idx == AW'(GROUPS - 1)) begin
          state_next = gva_pkg::SQ_IDLE;
        end
      end
      gva_pkg::SQ_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = gva_pkg::SQ_FETCH;
        end
      end
      gva_pkg::SQ_FETCH: state_next = gva_pkg::SQ_DECIDE;
      gva_pkg::SQ_DECIDE: begin
        if (req == gva_pkg::REQ_SAMPLE) begin
          if (!in_range || ent.poisoned) begin
            state_next = gva_pkg::SQ_IDLE;
          end else if (vna || wna) begin
            state_next = cfg.skip_missing ? gva_pkg::SQ_IDLE : gva_pkg::SQ_WRITE;
          end else if (cfg.stable_update) begin
            state_next = (wt_new == '0) ? gva_pkg::SQ_DE : gva_pkg::SQ_RATIO;
          end else begin
            state_next = gva_pkg::SQ_WX;
          end
        end else begin
          if (!in_range) begin
            state_next = gva_pkg::SQ_RESULT;
          end else if (!ent.seen || ent.poisoned || divv == '0) begin
            state_next = gva_pkg::SQ_WRITE;
          end else if (cfg.stable_update) begin
            state_next = gva_pkg::SQ_QUOT;
          end else if (ent.wt == '0) begin
            state_next = gva_pkg::SQ_WRITE;
          end else begin
            state_next = gva_pkg::SQ_M32;
          end
        end
      end
      gva_pkg::SQ_RATIO: begin
        arith_ctl = '{start: !issued, op: gva_pkg::AOP_DIV, sh: gva_pkg::SH_32};
        arith_a   = 64'(w);
        arith_b   = 64'(ent.wt);
        if (arith_done) state_next = gva_pkg::SQ_STEP;
      end
      gva_pkg::SQ_STEP: begin
        arith_ctl = '{start: !issued, op: gva_pkg::AOP_MUL, sh: gva_pkg::SH_32};
        arith_a   = 64'(d1_mag);
        arith_b   = tmp;
        if (arith_done) state_next = gva_pkg::SQ_DE;
      end
      gva_pkg::SQ_DE: begin
        arith_ctl = '{start: !issued, op: gva_pkg::AOP_MUL, sh: gva_pkg::SH_48};
        arith_a   = 64'(d1_mag);
        arith_b   = 64'(e_mag);
        if (arith_done) state_next = gva_pkg::SQ_TERM;
      end
      gva_pkg::SQ_TERM: begin
        arith_ctl = '{start: !issued, op: gva_pkg::AOP_MUL, sh: gva_pkg::SH_16};
        arith_a   = tmp;
        arith_b   = 64'(w);
        if (arith_done) state_next = gva_pkg::SQ_WRITE;
      end
      gva_pkg::SQ_WX: begin
        arith_ctl = '{start: !issued, op: gva_pkg::AOP_MUL, sh: gva_pkg::SH_16};
        arith_a   = 64'(x_mag);
        arith_b   = 64'(w);
        if (arith_done) state_next = gva_pkg::SQ_XX;
      end
      gva_pkg::SQ_XX: begin
        arith_ctl = '{start: !issued, op: gva_pkg::AOP_MUL, sh: gva_pkg::SH_16};
        arith_a   = 64'(x_mag);
        arith_b   = 64'(x_mag);
        if (arith_done) state_next = gva_pkg::SQ_WXX;
      end
      gva_pkg::SQ_WXX: begin
        arith_ctl = '{start: !issued, op: gva_pkg::AOP_MUL, sh: gva_pkg::SH_16};
        arith_a   = tmp;
        arith_b   = 64'(w);
        if (arith_done) state_next = gva_pkg::SQ_WRITE;
      end
      gva_pkg::SQ_M32: begin
        arith_ctl = '{start: !issued, op: gva_pkg::AOP_DIV, sh: gva_pkg::SH_32};
        arith_a   = sum_mag;
        arith_b   = 64'(ent.wt);
        if (arith_done) state_next = gva_pkg::SQ_C1;
      end
      gva_pkg::SQ_C1: begin
        arith_ctl = '{start: !issued, op: gva_pkg::AOP_MUL, sh: gva_pkg::SH_48};
        arith_a   = tmp;
        arith_b   = tmp;
        if (arith_done) state_next = gva_pkg::SQ_CORR;
      end
      gva_pkg::SQ_CORR: begin
        arith_ctl = '{start: !issued, op: gva_pkg::AOP_MUL, sh: gva_pkg::SH_16};
        arith_a   = tmp;
        arith_b   = 64'(ent.wt);
        if (arith_done) state_next = gva_pkg::SQ_QUOT;
      end
      gva_pkg::SQ_QUOT: begin
        arith_ctl = '{start: !issued, op: gva_pkg::AOP_DIV, sh: gva_pkg::SH_16};
        arith_a   = num;
        arith_b   = 64'(divv_mag);
        if (arith_done) begin
          state_next = (cfg.give_std_dev && !negq) ? gva_pkg::SQ_SQRT : gva_pkg::SQ_WRITE;
        end
      end
      gva_pkg::SQ_SQRT: begin
        arith_ctl = '{start: !issued, op: gva_pkg::AOP_SQRT, sh: gva_pkg::SH_16};
        arith_a   = {stat_v, 16'b0};
        if (arith_done) state_next = gva_pkg::SQ_WRITE;
      end
      gva_pkg::SQ_WRITE: begin
        mem_we = 1'b1;
        // a readout leaves the entry cleared
        if (req == gva_pkg::REQ_READOUT) begin
          wdata      = '0;
          state_next = gva_pkg::SQ_RESULT;
        end else begin
          state_next = gva_pkg::SQ_IDLE;
        end
      end
      gva_pkg::SQ_RESULT: begin
        if (res_space) begin
          res_push   = 1'b1;
          state_next = gva_pkg::SQ_IDLE;
        end
      end
      default: state_next = gva_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      issued  <= 1'b0;
    end else begin
      if (state == gva_pkg::SQ_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if (arith_done) begin
        issued <= 1'b0;
      end else if (arith_ctl.start) begin
        issued <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      gva_pkg::SQ_IDLE: begin
        if (in_valid) begin
          req      <= req_type;
          g        <= group;
          x        <= value;
          w        <= cfg.use_weights ? weight : gva_pkg::ONE_Q16;
          vna      <= value_is_na;
          wna      <= cfg.use_weights && weight_is_na;
          in_range <= ({7'b0, group} < 13'(GROUPS));
          na       <= 1'b0;
          neg      <= 1'b0;
        end
      end
      gva_pkg::SQ_FETCH: ent <= rd_data;
      gva_pkg::SQ_DECIDE: begin
        if (req == gva_pkg::REQ_SAMPLE) begin
          if (vna || wna) begin
            ent.poisoned <= 1'b1;
          end else begin
            ent.wt   <= wt_new;
            ent.seen <= 1'b1;
            d1       <= x32_ext - mean_ext;
            // first weight still zero: mean jumps to the sample
            if (cfg.stable_update && wt_new == '0) begin
              ent.mean <= x32;
            end
          end
        end else begin
          na  <= !in_range || !ent.seen || ent.poisoned || (divv == '0) ||
                 (!cfg.stable_update && ent.wt == '0);
          num <= ent.spread;
        end
      end
      gva_pkg::SQ_RATIO, gva_pkg::SQ_DE, gva_pkg::SQ_XX, gva_pkg::SQ_M32, gva_pkg::SQ_C1: begin
        if (arith_done) tmp <= arith_y;
      end
      gva_pkg::SQ_STEP: begin
        if (arith_done) begin
          ent.mean <= d1[48] ? 48'(mean_ext - $signed(arith_y[48:0]))
                             : 48'(mean_ext + $signed(arith_y[48:0]));
        end
      end
      gva_pkg::SQ_TERM, gva_pkg::SQ_WXX: begin
        if (arith_done) ent.spread <= spread_new;
      end
      gva_pkg::SQ_WX: begin
        if (arith_done) ent.sum <= sum_new;
      end
      gva_pkg::SQ_CORR: begin
        if (arith_done) begin
          if (ent.spread >= arith_y) begin
            num <= ent.spread - arith_y;
            neg <= 1'b0;
          end else begin
            num <= arith_y - ent.spread;
            neg <= 1'b1;
          end
        end
      end
      gva_pkg::SQ_QUOT: begin
        if (arith_done) begin
          if (negq && cfg.give_std_dev) begin
            na <= 1'b1;
          end
          if (negq) begin
            stat_v <= q_big ? gva_pkg::STAT_MIN : 48'(48'd0 - arith_y[47:0]);
          end else begin
            stat_v <= q_big ? gva_pkg::STAT_MAX : arith_y[47:0];
          end
        end
      end
      gva_pkg::SQ_SQRT: begin
        if (arith_done) stat_v <= arith_y[47:0];
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/grouped_variance_accumulator.sv =====
// Top level: configuration registers, result register, sequencer and shared arithmetic unit.
`timescale 1ns / 1ps

// Grouped variance accumulator.
// Input channel (in_valid/in_ready): req_type 0 adds a Q16.16 sample to its group,
// req_type 1 reads out the group's variance or standard deviation and clears it.
// Output channel (out_valid/out_ready): one item per readout, none per sample.
// One item at a time; in_ready is high only while the sequencer is idle. Every
// multiply, divide and square root goes through the single shared unit: a multiply
// sums four 32x32 partial products, a divide makes one quotient bit a cycle, and a
// square root is found bit by bit. A sample takes the running update or the
// one-pass path; an NA sample may instead poison its group. A readout may answer
// NA with no arithmetic; every readout waits for room in the result register.
// Reset: config returns to skip_missing=1, give_std_dev=1, use_weights=0,
// stable_update=1, and the group table is swept to zero, one entry a cycle,
// with in_ready low.
// A stalled receiver holds the result in the output register; the next item is
// still taken, and its readout waits until that register frees up.
// cfg_we writes cfg_data into register cfg_index; write only while idle.

module grouped_variance_accumulator #(
  parameter int GROUPS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [5:0]         group,
  input  logic signed [31:0] value,
  input  logic               value_is_na,
  input  logic [31:0]        weight,
  input  logic               weight_is_na,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         group_out,
  output logic signed [47:0] stat,
  output logic               stat_is_na,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [0:0]         cfg_data
);

  gva_pkg::cfg_t       cfg;
  gva_pkg::arith_ctl_t arith_ctl;
  gva_pkg::result_t    res;
  logic [63:0]         arith_a, arith_b, arith_y;
  logic                arith_done, res_space, res_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{skip_missing: 1'b1, give_std_dev: 1'b1, use_weights: 1'b0,
               stable_update: 1'b1};
    end else if (cfg_we) begin
      case (cfg_index)
        gva_pkg::CFG_SKIP_MISSING:  cfg.skip_missing  <= cfg_data[0];
        gva_pkg::CFG_GIVE_STD_DEV:  cfg.give_std_dev  <= cfg_data[0];
        gva_pkg::CFG_USE_WEIGHTS:   cfg.use_weights   <= cfg_data[0];
        gva_pkg::CFG_STABLE_UPDATE: cfg.stable_update <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign res_space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      group_out  <= res.group;
      stat       <= res.stat;
      stat_is_na <= res.na;
    end
  end

  gva_seq #(
    .GROUPS(GROUPS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .group       (group),
    .value       (value),
    .value_is_na (value_is_na),
    .weight      (weight),
    .weight_is_na(weight_is_na),
    .arith_ctl   (arith_ctl),
    .arith_a     (arith_a),
    .arith_b     (arith_b),
    .arith_y     (arith_y),
    .arith_done  (arith_done),
    .res_space   (res_space),
    .res_push    (res_push),
    .res         (res)
  );

  gva_arith u_arith (
    .clk (clk),
    .rst (rst),
    .ctl (arith_ctl),
    .a   (arith_a),
    .b   (arith_b),
    .y   (arith_y),
    .done(arith_done)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a second item back to back");

  a_sweep_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("ready during table sweep");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (res_space && !in_ready))
    else $error("result pushed without room or while idle");

  a_na_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stat_is_na) |-> (stat == '0))
    else $error("NA result with nonzero value");
`endif

endmodule

// ===== test/tb_grouped_variance_accumulator.sv =====
// Testbench for the grouped variance accumulator: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module tb_grouped_variance_accumulator;

  localparam int GROUPS     = 64;
  localparam int STALL_MAX  = 20000;
  localparam int DRAIN_WAIT = 400;
  localparam int PHASE_ITEMS = 70;

  typedef struct {
    bit        req;
    bit [5:0]  grp;
    bit [31:0] val;
    bit        vna;
    bit [31:0] w;
    bit        wna;
  } req_item_t;

  typedef struct {
    bit [5:0]  grp;
    bit [47:0] stat;
    bit        na;
  } readout_t;

  typedef struct {
    req_item_t it;
    bit        typed;
    readout_t  res;
  } dir_row_t;

  logic               clk, rst;
  logic               in_valid, in_ready;
  logic               req_type;
  logic [5:0]         group;
  logic signed [31:0] value;
  logic               value_is_na;
  logic [31:0]        weight;
  logic               weight_is_na;
  logic               out_valid, out_ready;
  logic [5:0]         group_out;
  logic signed [47:0] stat;
  logic               stat_is_na;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [0:0]         cfg_data;

  grouped_variance_accumulator #(.GROUPS(GROUPS)) u_dut (.*);

  // model copy of configuration and group table
  bit          m_skip, m_std, m_wts, m_stable;
  logic [63:0] g_wt[GROUPS];
  longint      g_mean[GROUPS];
  logic [63:0] g_spread[GROUPS];
  longint      g_sum[GROUPS];
  bit          g_seen[GROUPS];
  bit          g_poison[GROUPS];

  readout_t pending_readouts[$];
  int       err_count;
  int       stall_cyc;
  int       tx_idle, rx_idle;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mul_shr(input logic [63:0] a, b, input int sh);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> sh;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic logic [63:0] div_shl(input logic [63:0] num, den, input int sh);
    logic [127:0] t;
    if (den == 0 || den[63]) return '1;
    t = ({64'b0, num} << sh) / {64'b0, den};
    if (t[127:64] != 0) return '1;
    return t[63:0];
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r, trial;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] usat(input logic [63:0] a, b, lim);
    return (b > lim || a > lim - b) ? lim : a + b;
  endfunction

  function automatic longint ssat(input longint a, b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  function automatic void clear_entry(int g);
    g_wt[g] = 0; g_mean[g] = 0; g_spread[g] = 0; g_sum[g] = 0;
    g_seen[g] = 0; g_poison[g] = 0;
  endfunction

  function automatic void add_sample(int g, longint x, logic [63:0] w);
    logic [63:0] wt, step, term, wx, wxx;
    longint x32, d1, e;
    wt = usat(g_wt[g], w, 64'(gva_pkg::WT_MAX));
    g_wt[g] = wt;
    if (m_stable) begin
      x32 = x * 65536;
      d1 = x32 - g_mean[g];
      if (wt == 0) begin
        g_mean[g] = x32;
      end else begin
        step = mul_shr(mag64(d1), div_shl(w, wt, 32), 32);
        g_mean[g] += d1 < 0 ? -$signed(step) : $signed(step);
      end
      e = x32 - g_mean[g];
      term = mul_shr(mul_shr(mag64(d1), mag64(e), 48), w, 16);
      g_spread[g] = usat(g_spread[g], term, '1);
    end else begin
      wx = mul_shr(mag64(x), w, 16);
      wxx = mul_shr(mul_shr(mag64(x), mag64(x), 16), w, 16);
      g_sum[g] = ssat(g_sum[g], x < 0 ? -$signed(wx) : $signed(wx));
      g_spread[g] = usat(g_spread[g], wxx, '1);
    end
    g_seen[g] = 1;
  endfunction

  // returns 1 for NA
  function automatic bit group_stat(int g, output longint v);
    logic [63:0] wt, num, q, m32, corr;
    longint dv;
    bit neg;
    v = 0;
    neg = 0;
    wt = g_wt[g];
    dv = $signed(wt) - 65536;
    if (!g_seen[g] || g_poison[g] || dv == 0) return 1;
    if (m_stable) begin
      num = g_spread[g];
    end else begin
      if (wt == 0) return 1;
      m32 = div_shl(mag64(g_sum[g]), wt, 32);
      corr = mul_shr(mul_shr(m32, m32, 48), wt, 16);
      if (g_spread[g] >= corr) begin
        num = g_spread[g] - corr;
      end else begin
        num = corr - g_spread[g];
        neg = 1;
      end
    end
    q = div_shl(num, mag64(dv), 16);
    if (dv < 0) neg = !neg;
    if (q == 0) neg = 0;
    if (neg && m_std) return 1;
    if (!neg) v = q > 64'(gva_pkg::STAT_MAX) ? longint'(gva_pkg::STAT_MAX) : $signed(q);
    else v = q > 64'(gva_pkg::STAT_MAX) ? -longint'(gva_pkg::STAT_MAX) - 1 : -$signed(q);
    if (m_std) v = $signed(root_floor(64'(v) << 16));
    return 0;
  endfunction

  function automatic bit predict_item(req_item_t it, output readout_t r);
    logic [63:0] w;
    bit wna, na;
    longint v;
    int g;
    g = it.grp;
    w = m_wts ? 64'(it.w) : 64'(gva_pkg::ONE_Q16);
    wna = m_wts && it.wna;
    if (it.req == gva_pkg::REQ_SAMPLE) begin
      if (g_poison[g]) return 0;
      if (it.vna || wna) begin
        if (!m_skip) g_poison[g] = 1;
        return 0;
      end
      add_sample(g, longint'($signed(it.val)), w);
      return 0;
    end
    na = group_stat(g, v);
    clear_entry(g);
    r.grp = it.grp;
    r.stat = na ? 48'd0 : v[47:0];
    r.na = na;
    return 1;
  endfunction

  task automatic issue(input req_item_t it, input bit typed, input readout_t tres);
    bit fire;
    readout_t r;
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= it.req;
    group        <= it.grp;
    value        <= it.val;
    value_is_na  <= it.vna;
    weight       <= it.w;
    weight_is_na <= it.wna;
    do begin
      @(negedge clk);
      fire = in_valid && in_ready;
      @(posedge clk);
    end while (!fire);
    if (predict_item(it, r)) pending_readouts.push_back(typed ? tres : r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    // a trailing sample may still be in the arithmetic unit
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input bit d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      gva_pkg::CFG_SKIP_MISSING:  m_skip = d;
      gva_pkg::CFG_GIVE_STD_DEV:  m_std = d;
      gva_pkg::CFG_USE_WEIGHTS:   m_wts = d;
      default:                    m_stable = d;
    endcase
  endtask

  function automatic req_item_t rand_sample(bit [5:0] g);
    req_item_t it;
    it.req = gva_pkg::REQ_SAMPLE;
    it.grp = g;
    case ($urandom_range(3))
      0: it.val = $urandom();
      1: it.val = $urandom_range(32'h0008_0000);
      2: it.val = -$urandom_range(32'h0008_0000);
      default: it.val = $urandom_range(32'h0000_4000) - 32'h2000;
    endcase
    case ($urandom_range(4))
      0: it.w = $urandom();
      1: it.w = $urandom_range(32'h0000_FFFF);
      2: it.w = 0;
      3: it.w = gva_pkg::ONE_Q16;
      default: it.w = $urandom_range(32'h0004_0000);
    endcase
    it.vna = ($urandom_range(19) == 0);
    it.wna = ($urandom_range(19) == 0);
    return it;
  endfunction

  // output monitor, scoreboard and watchdog
  always @(negedge clk) begin
    readout_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_readouts.size() == 0) begin
        $error("unexpected result item: group_out %0d stat %h", group_out, stat);
        err_count++;
      end else begin
        e = pending_readouts.pop_front();
        if (group_out !== e.grp) begin
          $error("group_out: expected %0d, got %0d", e.grp, group_out);
          err_count++;
        end
        if (stat !== e.stat) begin
          $error("stat: expected %h, got %h", e.stat, stat);
          err_count++;
        end
        if (stat_is_na !== e.na) begin
          $error("stat_is_na: expected %0b, got %0b", e.na, stat_is_na);
          err_count++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cyc = 0;
    else stall_cyc++;
    if (stall_cyc >= STALL_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle);
  end

  dir_row_t dir_tab[$];
  readout_t na0;

  function automatic dir_row_t row(bit req, bit [5:0] g, bit [31:0] v, bit vna,
                                   bit [31:0] w, bit wna, bit typed,
                                   bit [47:0] st, bit na);
    dir_row_t d;
    d.it = '{req, g, v, vna, w, wna};
    d.typed = typed;
    d.res = '{g, st, na};
    return d;
  endfunction

  initial begin
    bit [3:0] modes[10];
    req_item_t it;
    int n, burst;
    bit [5:0] g;
    modes = '{4'b1101, 4'b0000, 4'b1111, 4'b0110, 4'b1011,
              4'b0010, 4'b1100, 4'b0101, 4'b1001, 4'b0001};
    rst = 1'b1;
    in_valid <= 1'b0; req_type <= gva_pkg::REQ_SAMPLE; group <= '0; value <= '0;
    value_is_na <= 1'b0; weight <= '0; weight_is_na <= 1'b0;
    cfg_we <= 1'b0; cfg_index <= gva_pkg::CFG_SKIP_MISSING; cfg_data <= '0;
    err_count = 0; stall_cyc = 0;
    tx_idle = 19; rx_idle = 77;
    m_skip = 1; m_std = 1; m_wts = 0; m_stable = 1;
    for (int i = 0; i < GROUPS; i++) clear_entry(i);

    // directed part, reset configuration
    dir_tab.push_back(row(gva_pkg::REQ_READOUT, 0, 0, 0, 0, 0, 1, 0, 1));   // empty group
    dir_tab.push_back(row(gva_pkg::REQ_SAMPLE, 1, 32'h7FFF_FFFF, 0, '1, 1, 0, 0, 0));
    dir_tab.push_back(row(gva_pkg::REQ_SAMPLE, 1, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(gva_pkg::REQ_READOUT, 1, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(gva_pkg::REQ_SAMPLE, 2, 32'h0005_0000, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(gva_pkg::REQ_READOUT, 2, 0, 0, 0, 0, 1, 0, 1));   // zero divisor
    dir_tab.push_back(row(gva_pkg::REQ_SAMPLE, 3, '1, 1, 0, 0, 0, 0, 0));   // NA is skipped
    dir_tab.push_back(row(gva_pkg::REQ_SAMPLE, 3, 32'h0001_0000, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(gva_pkg::REQ_SAMPLE, 3, 32'h0003_0000, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(gva_pkg::REQ_SAMPLE, 3, 32'hFFFE_8000, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(gva_pkg::REQ_READOUT, 3, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(gva_pkg::REQ_SAMPLE, 63, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(gva_pkg::REQ_SAMPLE, 63, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(gva_pkg::REQ_READOUT, 63, 0, 0, 0, 0, 1, 0, 0));  // zero spread
    dir_tab.push_back(row(gva_pkg::REQ_READOUT, 3, 0, 0, 0, 0, 1, 0, 1));   // cleared by readout

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) issue(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

    for (int p = 0; p < 10; p++) begin
      drain();
      if (p == 4) begin tx_idle = 77; rx_idle = 19; end
      if (p == 7) begin tx_idle = 0; rx_idle = 0; end
      write_cfg(gva_pkg::CFG_SKIP_MISSING,  modes[p][3]);
      write_cfg(gva_pkg::CFG_GIVE_STD_DEV,  modes[p][2]);
      write_cfg(gva_pkg::CFG_USE_WEIGHTS,   modes[p][1]);
      write_cfg(gva_pkg::CFG_STABLE_UPDATE, modes[p][0]);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          // noise: any group, any request
          it = rand_sample(6'($urandom_range(63)));
          it.req = 1'($urandom_range(1));
          issue(it, 0, na0);
          n++;
        end else begin
          g = 6'($urandom_range(7));
          burst = int'($urandom_range(6));
          for (int k = 0; k < burst; k++) begin
            issue(rand_sample(g), 0, na0);
            n++;
          end
          it = rand_sample(g);
          it.req = gva_pkg::REQ_READOUT;
          issue(it, 0, na0);
          n++;
        end
      end
    end
    drain();
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
